### src/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// shared types and constants for the camera frame capture decimator
// ----------------------------------------------------------------------------
package cfd_pkg;

  // image store geometry
  localparam int IMAGE_PIXELS = 16384;
  localparam int ADDR_W       = $clog2(IMAGE_PIXELS);
  localparam int COUNT_W      = 15;
  localparam int PADDR_W      = 3;

  // item commands
  typedef enum logic [2:0] {
    CMD_SAMPLE     = 3'd0,
    CMD_READ_RISE  = 3'd1,
    CMD_READ_FALL  = 3'd2,
    CMD_PAUSE      = 3'd3,
    CMD_RESUME     = 3'd4,
    CMD_TAKE_IMAGE = 3'd5,
    CMD_READ_PIXEL = 3'd6
  } cmd_t;

  // register word indexes
  localparam logic REG_PIXEL_SKIP = 1'b0;

  // status of one item after the control stage
  typedef struct packed {
    logic               stored;
    logic               ready;
    logic               active;
    logic [COUNT_W-1:0] count;
    logic               rd_sel;
  } item_status_t;

  // store write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

endpackage

### src/cfd_apb_regs.sv
// ----------------------------------------------------------------------------
// cfd_apb_regs
// apb register file holding the pixel skip setting
// ----------------------------------------------------------------------------
module cfd_apb_regs
  import cfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [7:0]         pixel_skip
);

  logic wr_hit;

  // write strobe for the skip register word
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_PIXEL_SKIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_skip <= 8'd0;
    end else if (wr_hit) begin
      pixel_skip <= pwdata[7:0];
    end
  end

  // read back
  always_comb begin
    if (paddr[2] == REG_PIXEL_SKIP) begin
      prdata = {24'd0, pixel_skip};
    end else begin
      prdata = 32'd0;
    end
  end

  assign pready = 1'b1;

endmodule

### src/cfd_pixel_ram.sv
// ----------------------------------------------------------------------------
// cfd_pixel_ram
// image store, one write port and one registered read port
// ----------------------------------------------------------------------------
module cfd_pixel_ram
  import cfd_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [IMAGE_PIXELS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// cfd_ctrl
// capture state, decimation counter and the first pipeline stage
// ----------------------------------------------------------------------------
module cfd_ctrl
  import cfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   command,
  input  logic [7:0]   sample_value,
  input  logic [13:0]  pixel_index,
  input  logic [7:0]   pixel_skip,
  input  logic         s1_take,
  output logic         s1_valid,
  output item_status_t s1_status,
  output ram_wr_t      ram_wr,
  output logic         ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr
);

  logic [COUNT_W-1:0] write_index, write_index_next;
  logic [7:0]         skip_count, skip_count_next;
  logic               capturing, capturing_next;
  logic               ready_flag, ready_flag_next;
  logic               acquire_enabled, acquire_enabled_next;
  logic               accept;
  logic               stored;
  logic               rd_sel;
  logic               not_full;

  assign in_ready = !s1_valid || s1_take;
  assign accept   = in_valid && in_ready;
  assign not_full = 32'(write_index) < IMAGE_PIXELS;

  // next state for one item
  always_comb begin
    write_index_next     = write_index;
    skip_count_next      = skip_count;
    capturing_next       = capturing;
    ready_flag_next      = ready_flag;
    acquire_enabled_next = acquire_enabled;
    stored               = 1'b0;
    rd_sel               = 1'b0;
    case (command)
      CMD_SAMPLE: begin
        if (acquire_enabled && capturing && not_full) begin
          if (skip_count != 8'd0) begin
            skip_count_next = skip_count - 8'd1;
          end else begin
            stored           = 1'b1;
            write_index_next = write_index + COUNT_W'(1);
            skip_count_next  = pixel_skip;
          end
        end
      end
      CMD_READ_RISE: begin
        if (acquire_enabled) begin
          capturing_next   = 1'b1;
          write_index_next = '0;
          ready_flag_next  = 1'b0;
        end
      end
      CMD_READ_FALL: begin
        capturing_next = 1'b0;
        if (acquire_enabled) begin
          ready_flag_next = 1'b1;
        end
      end
      CMD_PAUSE:      acquire_enabled_next = 1'b0;
      CMD_RESUME:     acquire_enabled_next = 1'b1;
      CMD_TAKE_IMAGE: ready_flag_next = 1'b0;
      CMD_READ_PIXEL: rd_sel = 32'(pixel_index) < IMAGE_PIXELS;
      default: ;
    endcase
  end

  // store access for this item
  assign ram_wr.en    = accept && stored;
  assign ram_wr.addr  = write_index[ADDR_W-1:0];
  assign ram_wr.data  = sample_value;
  assign ram_rd_en    = accept;
  assign ram_rd_addr  = pixel_index[ADDR_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index     <= '0;
      skip_count      <= 8'd0;
      capturing       <= 1'b0;
      ready_flag      <= 1'b0;
      acquire_enabled <= 1'b0;
      s1_valid        <= 1'b0;
    end else begin
      if (accept) begin
        write_index     <= write_index_next;
        skip_count      <= skip_count_next;
        capturing       <= capturing_next;
        ready_flag      <= ready_flag_next;
        acquire_enabled <= acquire_enabled_next;
        s1_valid        <= 1'b1;
      end else if (s1_take) begin
        s1_valid        <= 1'b0;
      end
    end
  end

  // stage payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status.stored <= stored;
      s1_status.ready  <= ready_flag_next;
      s1_status.active <= capturing_next;
      s1_status.count  <= write_index_next;
      s1_status.rd_sel <= rd_sel;
    end
  end

endmodule

### src/camera_frame_capture_decimator.sv
// ----------------------------------------------------------------------------
// camera_frame_capture_decimator
// frame grabber with sample decimation and pixel read back
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry a command, a sample value and a
//   pixel index. Every input beat gives exactly one output beat
//   (out_valid/out_ready) with the read pixel and the capture status after
//   that beat. The pixel_skip register is written over the APB port; the
//   user must write it only while the block is idle, the block does not
//   enforce this. An input beat passes through the control stage, where
//   the state is updated and the image store is written or read, and then
//   into the output register. Throughput is one beat per cycle while the
//   receiver does not stall, since each beat needs at most one store write
//   or one store read.
//   When the receiver stalls, the output register holds its beat and the
//   control stage holds one more; in_ready drops only when both are full.
//   Reset (rst, synchronous) clears the capture state, the skip counter,
//   the pixel_skip register and both stages. The image store is not
//   cleared: entries read before they are written return arbitrary data.
// ----------------------------------------------------------------------------
module camera_frame_capture_decimator
  import cfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic [7:0]         sample_value,
  input  logic [13:0]        pixel_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         pixel_data,
  output logic               sample_stored,
  output logic               frame_ready,
  output logic               capture_active,
  output logic [14:0]        pixel_count
);

  logic [7:0]        pixel_skip;
  logic              s1_valid;
  logic              s1_take;
  item_status_t      s1_status;
  ram_wr_t           ram_wr;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;

  cfd_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pixel_skip (pixel_skip)
  );

  cfd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .sample_value (sample_value),
    .pixel_index  (pixel_index),
    .pixel_skip   (pixel_skip),
    .s1_take      (s1_take),
    .s1_valid     (s1_valid),
    .s1_status    (s1_status),
    .ram_wr       (ram_wr),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr)
  );

  cfd_pixel_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register loads whenever it is empty or being drained
  assign s1_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= s1_valid;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (s1_take && s1_valid) begin
      pixel_data     <= s1_status.rd_sel ? ram_rd_data : 8'd0;
      sample_stored  <= s1_status.stored;
      frame_ready    <= s1_status.ready;
      capture_active <= s1_status.active;
      pixel_count    <= s1_status.count;
    end
  end

endmodule
